FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion forms; every user has clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// condition at one edge implies a result at the next edge
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/core/crbd_pkg.sv
// ----------------------------------------------------------------------------
// crbd_pkg
// Shared constants and types of the column run branch detector.
// ----------------------------------------------------------------------------
package crbd_pkg;

  localparam int MAX_ROWS_DEF = 1024;
  localparam int MAX_COLS_DEF = 4096;

  localparam int ROWS_RESET = 480;
  localparam int COLS_RESET = 640;

  localparam int PIX_W      = 8;
  localparam int ROWS_CFG_W = 11;
  localparam int COLS_CFG_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_ADDR_W = 1;
  localparam int X_W        = 12;
  localparam int Y_W        = 10;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_ROWS = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_COLS = 1'b1;

  localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;

  // position flags of one pixel within its column
  typedef struct packed {
    logic first;
    logic last;
  } ctl_t;

endpackage

FILE: rtl/core/crbd_ram.sv
// ----------------------------------------------------------------------------
// crbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crbd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/crbd_seq.sv
// ----------------------------------------------------------------------------
// crbd_seq
// Size registers and row/column counters; tags each accepted pixel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crbd_seq #(
  parameter int MAX_ROWS = crbd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = crbd_pkg::MAX_COLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [crbd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [crbd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                acc,
  output logic [$clog2(MAX_ROWS)-1:0]         row,
  output logic [$clog2(MAX_COLS)-1:0]         col,
  output crbd_pkg::ctl_t                      ctl
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int RCW = ((RW > crbd_pkg::ROWS_CFG_W) ? RW : crbd_pkg::ROWS_CFG_W) + 1;
  localparam int CCW = ((CW > crbd_pkg::COLS_CFG_W) ? CW : crbd_pkg::COLS_CFG_W) + 1;

  // saturate the height into [2, MAX_ROWS] and return the last row index
  function automatic logic [RW-1:0] rows_last_of(input logic [crbd_pkg::ROWS_CFG_W-1:0] v);
    logic [RCW-1:0] w;
    logic [RCW-1:0] r;
    w = RCW'(v);
    if (w < RCW'(2)) begin
      r = RCW'(1);
    end else if (w > RCW'(MAX_ROWS)) begin
      r = RCW'(MAX_ROWS - 1);
    end else begin
      r = w - RCW'(1);
    end
    return RW'(r);
  endfunction

  function automatic logic [CW-1:0] cols_last_of(input logic [crbd_pkg::COLS_CFG_W-1:0] v);
    logic [CCW-1:0] w;
    logic [CCW-1:0] r;
    w = CCW'(v);
    if (w < CCW'(2)) begin
      r = CCW'(1);
    end else if (w > CCW'(MAX_COLS)) begin
      r = CCW'(MAX_COLS - 1);
    end else begin
      r = w - CCW'(1);
    end
    return CW'(r);
  endfunction

  logic [RW-1:0] rows_last;
  logic [CW-1:0] cols_last;
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count;
  logic          at_last;

  assign at_last   = (row_count >= rows_last);
  assign row       = row_count;
  assign col       = col_count;
  assign ctl.first = (row_count == '0);
  assign ctl.last  = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_last <= rows_last_of(crbd_pkg::ROWS_CFG_W'(crbd_pkg::ROWS_RESET));
      cols_last <= cols_last_of(crbd_pkg::COLS_CFG_W'(crbd_pkg::COLS_RESET));
    end else if (cfg_we) begin
      if (cfg_addr == crbd_pkg::REG_IMAGE_ROWS) begin
        rows_last <= rows_last_of(cfg_wdata[crbd_pkg::ROWS_CFG_W-1:0]);
      end
      if (cfg_addr == crbd_pkg::REG_IMAGE_COLS) begin
        cols_last <= cols_last_of(cfg_wdata[crbd_pkg::COLS_CFG_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (acc) begin
      if (at_last) begin
        row_count <= '0;
        // wrap at the frame end, also when the width shrank below the count
        if (col_count >= cols_last) begin
          col_count <= '0;
        end else begin
          col_count <= col_count + CW'(1);
        end
      end else begin
        row_count <= row_count + RW'(1);
      end
    end
  end

  `ASSERT_NEXT(a_row_wrap, acc && at_last, row_count == '0, "row counter did not wrap after last row")
  `ASSERT_ALWAYS(a_first_not_last, !(ctl.first && ctl.last), "row zero tagged as last row")

endmodule

FILE: rtl/core/crbd_run.sv
// ----------------------------------------------------------------------------
// crbd_run
// Run tracker: evaluates one pixel against the line store, updates the run
// state, writes the line store back and holds the result word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crbd_run #(
  parameter int MAX_ROWS = crbd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = crbd_pkg::MAX_COLS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 acc,
  output logic                                 in_ready,
  input  logic [crbd_pkg::PIX_W-1:0]           pixel,
  input  logic [$clog2(MAX_ROWS)-1:0]          row,
  input  logic [$clog2(MAX_COLS)-1:0]          col,
  input  crbd_pkg::ctl_t                       ctl,
  input  logic                                 pz,
  output logic                                 mem_we,
  output logic [$clog2(MAX_ROWS)-1:0]          mem_waddr,
  output logic                                 mem_wdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [crbd_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);

  // pixel stage, aligned with the line store read data
  logic                       s1_valid;
  logic [crbd_pkg::PIX_W-1:0] s1_pixel;
  logic [RW-1:0]              s1_row;
  logic [CW-1:0]              s1_col;
  crbd_pkg::ctl_t             s1_ctl;

  logic          in_white, in_white_next;
  logic [RW-1:0] run_start, run_start_next;
  logic          run_clear, run_clear_next;

  logic          is_white, is_black;
  logic          emit, emit_clear;
  logic [RW-1:0] emit_y;
  logic          produce, out_free, adv;
  logic [CW-1:0] x_m1;

  assign is_white = (s1_pixel == crbd_pkg::PIX_WHITE);
  assign is_black = (s1_pixel == crbd_pkg::PIX_BLACK);

  always_comb begin
    in_white_next  = in_white;
    run_start_next = run_start;
    run_clear_next = run_clear;
    emit           = 1'b0;
    emit_clear     = 1'b0;
    emit_y         = run_start;
    if (s1_ctl.first) begin
      if (is_white) begin
        in_white_next = 1'b1;
      end else begin
        in_white_next  = 1'b0;
        run_start_next = '0;
        run_clear_next = !pz;
      end
    end else if (!s1_ctl.last) begin
      if (!in_white) begin
        if (is_white) begin
          emit          = 1'b1;
          emit_clear    = run_clear;
          in_white_next = 1'b1;
        end else begin
          run_clear_next = run_clear && !pz;
        end
      end else if (is_black) begin
        in_white_next  = 1'b0;
        run_start_next = s1_row;
        run_clear_next = !pz;
      end
    end else begin
      // end rules: an open run closes; a lone black pixel is a one-row run
      if (!in_white) begin
        emit       = 1'b1;
        emit_clear = is_white ? run_clear : (run_clear && !pz);
      end else if (is_black) begin
        emit       = 1'b1;
        emit_y     = s1_row;
        emit_clear = !pz;
      end
      in_white_next  = 1'b0;
      run_start_next = '0;
      run_clear_next = 1'b1;
    end
  end

  assign produce  = s1_valid && emit && emit_clear && (s1_col != '0);
  assign out_free = !m_tvalid || m_tready;
  // pixels without a result pass even while the result word waits
  assign adv      = s1_valid && (!produce || out_free);
  assign in_ready = !s1_valid || adv;

  assign mem_we    = adv;
  assign mem_waddr = s1_row;
  assign mem_wdata = is_black;

  assign x_m1 = s1_col - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pixel <= pixel;
      s1_row   <= row;
      s1_col   <= col;
      s1_ctl   <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_white  <= 1'b0;
      run_start <= '0;
      run_clear <= 1'b1;
    end else if (adv) begin
      in_white  <= in_white_next;
      run_start <= run_start_next;
      run_clear <= run_clear_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (produce && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce && out_free) begin
      m_tdata <= {{(crbd_pkg::OUT_TDATA_W - crbd_pkg::X_W - crbd_pkg::Y_W){1'b0}},
                  crbd_pkg::Y_W'(emit_y), crbd_pkg::X_W'(x_m1)};
    end
  end

  `ASSERT_ALWAYS(a_no_col0_result, !(produce && out_free) || (s1_col != '0), "result from column zero")
  `ASSERT_NEXT(a_column_end, adv && s1_ctl.last, run_clear && !in_white, "run state not reset at column end")
  `ASSERT_ALWAYS(a_stall_cause, in_ready || (s1_valid && produce && m_tvalid), "input stalled without a pending result")

endmodule

FILE: rtl/core/column_run_branch_detector.sv
// ----------------------------------------------------------------------------
// column_run_branch_detector
// Finds dark runs per image column and reports those with no black pixel
// beside them in the previous column, kept in a one-bit line store.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_*       in   tvalid/tready      tdata[7:0] pixel
// m_*       out  tvalid/tready      tdata[11:0] branch_x, [21:12] branch_y
// cfg_*     in   cfg_we             cfg_addr register index, cfg_wdata value
//
// One pixel per cycle unless a waiting result stalls input; a pixel passes the
// pixel stage before its result is registered. The line store read for a pixel is
// issued on acceptance and used when the pixel updates the run state and writes its bit back.
// Reset (rst, synchronous) clears counters and run state and loads the sizes
// 480 x 640; the line store is not cleared.
// A waiting result stalls input only when the next pixel also makes a result.
// ----------------------------------------------------------------------------
module column_run_branch_detector #(
  parameter int MAX_ROWS = crbd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = crbd_pkg::MAX_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [crbd_pkg::PIX_W-1:0]       s_tdata,   // [7:0] pixel
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [crbd_pkg::OUT_TDATA_W-1:0] m_tdata,   // [11:0] branch_x, [21:12] branch_y
  input  logic                             cfg_we,
  input  logic [crbd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [crbd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);

  logic           acc;
  logic [RW-1:0]  row;
  logic [CW-1:0]  col;
  crbd_pkg::ctl_t ctl;
  logic           pz;
  logic           mem_we;
  logic [RW-1:0]  mem_waddr;
  logic           mem_wdata;

  assign acc = s_tvalid && s_tready;

  crbd_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .row       (row),
    .col       (col),
    .ctl       (ctl)
  );

  crbd_ram #(
    .WIDTH (1),
    .DEPTH (MAX_ROWS)
  ) u_line (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (acc),
    .raddr (row),
    .rdata (pz)
  );

  crbd_run #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_run (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .in_ready  (s_tready),
    .pixel     (s_tdata),
    .row       (row),
    .col       (col),
    .ctl       (ctl),
    .pz        (pz),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

FILE: tb/column_run_branch_detector_tb.sv
// ----------------------------------------------------------------------------
// column_run_branch_detector_tb
// Streams pixels through the column run branch detector and checks each branch
// word against a cycle-free predictor of the run tracking and line store.
// Sizes change between phases, including out-of-range and mid-frame values.
// ----------------------------------------------------------------------------
module column_run_branch_detector_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 8;
  localparam int RAND_ITEMS  = 950;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [crbd_pkg::X_W-1:0] x;
    logic [crbd_pkg::Y_W-1:0] y;
  } branch_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [crbd_pkg::PIX_W-1:0]       s_tdata = '0;    // [7:0] pixel
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [crbd_pkg::OUT_TDATA_W-1:0] m_tdata;         // [11:0] branch_x, [21:12] branch_y
  logic                             cfg_we = 1'b0;
  logic [crbd_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [crbd_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  column_run_branch_detector dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  bit                              prev_dark [crbd_pkg::MAX_ROWS_DEF];
  logic [crbd_pkg::ROWS_CFG_W-1:0] rows_reg = crbd_pkg::ROWS_CFG_W'(crbd_pkg::ROWS_RESET);
  logic [crbd_pkg::COLS_CFG_W-1:0] cols_reg = crbd_pkg::COLS_CFG_W'(crbd_pkg::COLS_RESET);
  logic [9:0]                      row_cnt = '0;
  logic [11:0]                     col_cnt = '0;
  bit                              in_white = 1'b0;
  logic [9:0]                      run_top = '0;
  bit                              run_clean = 1'b1;

  logic [crbd_pkg::PIX_W-1:0] pixel_q [$];
  branch_t                    branch_q [$];
  int                         n_pushed = 0;
  int                         n_accepted = 0;
  int                         n_branches = 0;
  int                         fail_cnt = 0;
  int                         cyc = 0;
  bit                         s_took = 1'b0;
  bit                         no_gaps = 1'b0;
  bit                         rx_hold_go = 1'b0;
  bit                         rx_hold_done = 1'b0;
  int                         hold_cnt = 0;

  function automatic int clamp_size(int v, int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  // run tracking for one accepted pixel; queues the branch it causes, if any
  task automatic track_pixel(input logic [crbd_pkg::PIX_W-1:0] v);
    int      rows;
    int      cols;
    int      r;
    bit      last;
    bit      pz;
    bit      closes;
    bit      clean;
    int      top;
    branch_t b;
    rows   = clamp_size(rows_reg, crbd_pkg::MAX_ROWS_DEF);
    cols   = clamp_size(cols_reg, crbd_pkg::MAX_COLS_DEF);
    r      = row_cnt;
    last   = (r >= rows - 1);
    pz     = prev_dark[r];
    closes = 1'b0;
    clean  = 1'b0;
    top    = 0;
    if (r == 0) begin
      if (v == crbd_pkg::PIX_WHITE) begin
        in_white = 1'b1;
      end else begin
        in_white  = 1'b0;
        run_top   = '0;
        run_clean = !pz;
      end
    end else if (!last) begin
      if (!in_white) begin
        if (v == crbd_pkg::PIX_WHITE) begin
          closes   = 1'b1;
          clean    = run_clean;
          top      = run_top;
          in_white = 1'b1;
        end else begin
          run_clean = run_clean && !pz;
        end
      end else if (v == crbd_pkg::PIX_BLACK) begin
        in_white  = 1'b0;
        run_top   = crbd_pkg::Y_W'(r);
        run_clean = !pz;
      end
    end else begin
      if (!in_white) begin
        closes = 1'b1;
        top    = run_top;
        // a closing white pixel ends the run one row up
        clean  = (v == crbd_pkg::PIX_WHITE) ? run_clean : (run_clean && !pz);
      end else if (v == crbd_pkg::PIX_BLACK) begin
        closes = 1'b1;
        top    = r;
        clean  = !pz;
      end
    end
    if (closes && clean && col_cnt >= 1) begin
      b.x = col_cnt - 1'b1;
      b.y = crbd_pkg::Y_W'(top);
      branch_q = {branch_q, b};
      n_branches++;
    end
    prev_dark[r] = (v == crbd_pkg::PIX_BLACK);
    if (last) begin
      row_cnt   = '0;
      in_white  = 1'b0;
      run_top   = '0;
      run_clean = 1'b1;
      col_cnt   = (col_cnt >= cols - 1) ? '0 : col_cnt + 1'b1;
    end else begin
      row_cnt = crbd_pkg::Y_W'(r + 1);
    end
  endtask

  // acceptance, prediction and checking at the rising edge
  always @(posedge clk) begin
    branch_t want;
    cyc++;
    if (cyc >= CYCLE_LIMIT) begin
      $display("[column_run_branch_detector] ERROR");
      $finish;
    end
    s_took = !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      if (branch_q.size() == 0) begin
        $error("unexpected branch word: x %0d y %0d", m_tdata[11:0], m_tdata[21:12]);
        fail_cnt++;
      end else begin
        want = branch_q.pop_front();
        if (m_tdata[11:0] !== want.x) begin
          $error("branch_x: expected %0d, got %0d", want.x, m_tdata[11:0]);
          fail_cnt++;
        end
        if (m_tdata[21:12] !== want.y) begin
          $error("branch_y: expected %0d, got %0d", want.y, m_tdata[21:12]);
          fail_cnt++;
        end
      end
    end
    if (s_took) begin
      track_pixel(s_tdata);
      n_accepted++;
    end
  end

  // pixel driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_took) begin
      if (pixel_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 21)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pixel_q.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (rx_hold_go && !rx_hold_done) begin
      hold_cnt     <= HOLD_CYCLES;
      rx_hold_done <= 1'b1;
    end
  end

  always @(negedge clk) begin
    m_tready <= (hold_cnt == 0) && (no_gaps || $urandom_range(0, 99) >= 21);
  end

  function automatic logic [crbd_pkg::PIX_W-1:0] pick_pixel();
    int k;
    k = $urandom_range(0, 99);
    if (k < 30) return crbd_pkg::PIX_WHITE;
    if (k < 45) return crbd_pkg::PIX_BLACK;
    if (k < 50) return k[0] ? 8'h01 : 8'hFE;
    return crbd_pkg::PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [crbd_pkg::CFG_DATA_W-1:0] pick_rows();
    case ($urandom_range(0, 19))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'd2;
      3:       return 13'd1024;
      4:       return crbd_pkg::CFG_DATA_W'($urandom_range(0, 8191));
      default: return crbd_pkg::CFG_DATA_W'($urandom_range(2, 12) |
                                            ($urandom_range(0, 3) << crbd_pkg::ROWS_CFG_W));
    endcase
  endfunction

  function automatic logic [crbd_pkg::CFG_DATA_W-1:0] pick_cols();
    case ($urandom_range(0, 19))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'd2;
      3:       return 13'd4096;
      4:       return 13'd8191;
      5:       return crbd_pkg::CFG_DATA_W'($urandom_range(0, 8191));
      default: return crbd_pkg::CFG_DATA_W'($urandom_range(2, 6));
    endcase
  endfunction

  task automatic write_reg(input logic [crbd_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [crbd_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == crbd_pkg::REG_IMAGE_ROWS) rows_reg = val[crbd_pkg::ROWS_CFG_W-1:0];
    else cols_reg = val;
  endtask

  task automatic push_pixel(input logic [crbd_pkg::PIX_W-1:0] v);
    pixel_q = {pixel_q, v};
    n_pushed++;
  endtask

  // hold the sender until every pixel is taken and every branch has come out
  task automatic wait_drained();
    while (n_accepted != n_pushed || branch_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    logic [crbd_pkg::PIX_W-1:0] directed [24];
    int                         phase;
    int                         n_rand;
    int                         len;
    int                         k;
    directed = '{8'd0, 8'd0, 8'd0,      8'd100, 8'd255, 8'd0,
                 8'd255, 8'd0, 8'd255,  8'd7, 8'd255, 8'd128,
                 8'd255, 8'd255, 8'd0,  8'd1, 8'd254, 8'd255,
                 8'd255, 8'd0, 8'd200,  8'd128, 8'd128, 8'd128};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // two full frames of 3 x 4: run openings, closings and all end-of-column rules
    write_reg(crbd_pkg::REG_IMAGE_ROWS, 13'd3);
    write_reg(crbd_pkg::REG_IMAGE_COLS, 13'd4);
    @(posedge clk);
    foreach (directed[i]) push_pixel(directed[i]);
    wait_drained();

    // full-height frame of two columns, height clamped to its maximum and width to its minimum; column zero
    // fills the whole line store, so later size changes never read stale rows
    write_reg(crbd_pkg::REG_IMAGE_ROWS, 13'h1FFF);
    write_reg(crbd_pkg::REG_IMAGE_COLS, 13'd1);
    no_gaps = 1'b1;
    @(posedge clk);
    repeat (2 * crbd_pkg::MAX_ROWS_DEF) push_pixel(pick_pixel());
    wait_drained();
    no_gaps = 1'b0;

    phase  = 0;
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      k = $urandom_range(0, 9);
      if (phase == 0 || k < 3) write_reg(crbd_pkg::REG_IMAGE_ROWS, pick_rows());
      if (phase == 0 || (k >= 2 && k < 6)) write_reg(crbd_pkg::REG_IMAGE_COLS, pick_cols());
      if (phase == 2) rx_hold_go = 1'b1;
      len = (phase == 2) ? 150 : $urandom_range(10, 60);
      @(posedge clk);
      repeat (len) push_pixel(pick_pixel());
      n_rand += len;
      phase++;
      wait_drained();
    end

    repeat (SETTLE) @(posedge clk);
    if (branch_q.size() != 0) begin
      $error("%0d branch words never arrived", branch_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("[column_run_branch_detector] OK");
    end else begin
      $display("[column_run_branch_detector] ERROR");
    end
    $finish;
  end

endmodule
